// ----- hw/rtl/sws_pkg.sv -----
// shared types and constants of the sliding window sender
// no dependencies; imported by sliding_window_sender
package sws_pkg;

  localparam int unsigned WINDOW_MAX = 16;
  localparam int unsigned RING_AW    = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W      = RING_AW + 1;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned WIN_W      = 5;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned ADDR_W     = 3;

  // register indexes, decoded from paddr[2]
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_SEQ_STEP    = 1'b1;

  typedef enum logic [1:0] {
    FUNC_SEND  = 2'd0,
    FUNC_ACK   = 2'd1,
    FUNC_TIMER = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ACT_TX     = 2'd0,
    ACT_STOP   = 2'd1,
    ACT_START  = 2'd2,
    ACT_REFUSE = 2'd3
  } action_e;

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_SEND_START = 11'b000_0000_0010,
    S_ACK_RD     = 11'b000_0000_0100,
    S_ACK_EV     = 11'b000_0000_1000,
    S_ACK_START  = 11'b000_0001_0000,
    S_DUP_RD     = 11'b000_0010_0000,
    S_DUP_CHK    = 11'b000_0100_0000,
    S_TMO_RD     = 11'b000_1000_0000,
    S_TMO_TX     = 11'b001_0000_0000,
    S_TMO_STOP   = 11'b010_0000_0000,
    S_TMO_START  = 11'b100_0000_0000
  } state_e;

  // a is above b modulo 2^32
  function automatic logic is_above(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return (diff != '0) && !diff[SEQ_W-1];
  endfunction

endpackage

// ----- hw/rtl/sliding_window_sender.sv -----
// sliding window sender: top level, control sequencer and packet ring memory
// depends on sws_pkg
//
// usage
//   command channel: an item (func, payload word, ack number, checksum flag) is
//   taken at a rising edge with start high and busy low. results leave at most one
//   per cycle on the result ports, each marked by result_valid_o for one cycle;
//   last_o flags the final result of an item. the receiver cannot stall, so
//   results are simply pushed out as they are produced.
//   configuration: apb-style port, window_size at byte address 0, seq_step at
//   byte address 4. write only while busy is low and no results are pending.
// result sequence
//   a send or a refusal gives its first result in the cycle after the item is
//   taken; an item that reads the ring gives it after a read state, the ring read
//   register and the result register. the ring sits in a synchronous memory with
//   a registered read, which sets the pace of everything that looks at held packets:
//     send: tx, then start; refused send: one refuse result; corrupt or plain
//     duplicate ack, empty timer expiry: no result, back to idle
//     advancing ack: each held packet read, then stop; a kept packet also gets start
//     fast retransmit search: packets read in order; tx of the first that matches the ack
//     timer expiry: oldest packet read, then tx, stop, start. busy stays high until done
// reset
//   ring empty, base, next sequence number and duplicate tracker cleared,
//   window_size 4, seq_step 21. ring memory contents are not cleared.
module sliding_window_sender
  import sws_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             func_i,
  input  logic [DATA_W-1:0]      payload_word_i,
  input  logic [SEQ_W-1:0]       ack_number_i,
  input  logic                   ack_checksum_ok_i,
  // result channel
  output logic                   result_valid_o,
  output logic [1:0]             action_o,
  output logic [SEQ_W-1:0]       seq_number_o,
  output logic [DATA_W-1:0]      packet_data_o,
  output logic                   last_o,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // configuration registers
  logic [WIN_W-1:0]  window_size_q;
  logic [STEP_W-1:0] seq_step_q;

  // sequencer state
  state_e            state_q, state_d;
  logic [RING_AW-1:0] ring_head_q, ring_head_d;
  logic [CNT_W-1:0]  held_count_q, held_count_d;
  logic [SEQ_W-1:0]  window_base_q, window_base_d;
  logic [SEQ_W-1:0]  next_seq_q, next_seq_d;
  logic [SEQ_W-1:0]  last_dup_ack_q, last_dup_ack_d;
  logic [1:0]        dup_count_q, dup_count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  retired_q, retired_d;
  logic              retiring_q, retiring_d;
  logic [SEQ_W-1:0]  ack_q, ack_d;

  // result register
  logic              res_valid_q, res_valid_d;
  action_e           res_action_q, res_action_d;
  logic [SEQ_W-1:0]  res_seq_q, res_seq_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              res_last_q, res_last_d;

  // ring memory: {seq, data} per entry
  logic [SEQ_W+DATA_W-1:0] ring_mem [WINDOW_MAX];
  logic [SEQ_W+DATA_W-1:0] rd_data_q;
  logic [RING_AW-1:0]      rd_addr, wr_addr;
  logic                    mem_we;
  logic [SEQ_W-1:0]        rd_seq;
  logic [DATA_W-1:0]       rd_payload;

  logic              accept;
  logic              cfg_we;
  logic [CNT_W-1:0]  limit;
  logic              window_full;
  logic              is_last_entry;
  logic              below;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign cfg_we  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // window limit saturates at the ring depth
  assign limit       = (window_size_q > WIN_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX)
                                                            : CNT_W'(window_size_q);
  assign window_full = (held_count_q >= limit);

  assign rd_addr    = ring_head_q + idx_q[RING_AW-1:0];
  assign wr_addr    = ring_head_q + held_count_q[RING_AW-1:0];
  assign rd_seq     = rd_data_q[SEQ_W+DATA_W-1:DATA_W];
  assign rd_payload = rd_data_q[DATA_W-1:0];

  assign is_last_entry = ((idx_q + CNT_W'(1)) == held_count_q);
  assign below         = retiring_q && is_above(ack_q, rd_seq);

  // configuration register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WIN_W'(4);
      seq_step_q    <= STEP_W'(21);
    end else if (cfg_we) begin
      case (paddr[2])
        REG_WINDOW_SIZE: window_size_q <= pwdata[WIN_W-1:0];
        REG_SEQ_STEP:    seq_step_q    <= pwdata[STEP_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WINDOW_SIZE: prdata = {{(32-WIN_W){1'b0}}, window_size_q};
      REG_SEQ_STEP:    prdata = {{(32-STEP_W){1'b0}}, seq_step_q};
      default:         prdata = '0;
    endcase
  end

  // ring memory, written only on a send that is not refused; the read taken while writing is unused
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= {next_seq_q, payload_word_i};
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  always_comb begin
    state_d        = state_q;
    ring_head_d    = ring_head_q;
    held_count_d   = held_count_q;
    window_base_d  = window_base_q;
    next_seq_d     = next_seq_q;
    last_dup_ack_d = last_dup_ack_q;
    dup_count_d    = dup_count_q;
    idx_d          = idx_q;
    retired_d      = retired_q;
    retiring_d     = retiring_q;
    ack_d          = ack_q;
    mem_we         = 1'b0;

    res_valid_d  = 1'b0;
    res_action_d = ACT_TX;
    res_seq_d    = '0;
    res_data_d   = '0;
    res_last_d   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ack_d      = ack_number_i;
          idx_d      = '0;
          retired_d  = '0;
          retiring_d = 1'b1;
          case (func_i)
            FUNC_SEND: begin
              res_valid_d = 1'b1;
              res_seq_d   = next_seq_q;
              if (window_full) begin
                res_action_d = ACT_REFUSE;
                res_last_d   = 1'b1;
              end else begin
                mem_we       = 1'b1;
                held_count_d = held_count_q + CNT_W'(1);
                res_action_d = ACT_TX;
                res_data_d   = payload_word_i;
                state_d      = S_SEND_START;
              end
            end
            FUNC_ACK: begin
              if (ack_checksum_ok_i) begin
                if (is_above(ack_number_i, window_base_q)) begin
                  window_base_d  = ack_number_i;
                  last_dup_ack_d = ack_number_i;
                  dup_count_d    = '0;
                  if (held_count_q != '0) begin
                    state_d = S_ACK_RD;
                  end
                end else if (ack_number_i == last_dup_ack_q) begin
                  if (dup_count_q != 2'd3) begin
                    dup_count_d = dup_count_q + 2'd1;
                    // third identical duplicate triggers the fast retransmit search
                    if (dup_count_q == 2'd2 && held_count_q != '0) begin
                      state_d = S_DUP_RD;
                    end
                  end
                end else begin
                  last_dup_ack_d = ack_number_i;
                  dup_count_d    = 2'd1;
                end
              end
            end
            FUNC_TIMER: begin
              if (held_count_q != '0) begin
                state_d = S_TMO_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_SEND_START: begin
        res_valid_d  = 1'b1;
        res_action_d = ACT_START;
        res_seq_d    = next_seq_q;
        res_last_d   = 1'b1;
        next_seq_d   = next_seq_q + SEQ_W'(seq_step_q);
        state_d      = S_IDLE;
      end

      S_ACK_RD: begin
        state_d = S_ACK_EV;
      end

      S_ACK_EV: begin
        res_valid_d  = 1'b1;
        res_action_d = ACT_STOP;
        res_seq_d    = rd_seq;
        if (below) begin
          res_last_d = is_last_entry;
          retired_d  = retired_q + CNT_W'(1);
          idx_d      = idx_q + CNT_W'(1);
          if (is_last_entry) begin
            ring_head_d  = ring_head_q + retired_d[RING_AW-1:0];
            held_count_d = held_count_q - retired_d;
            state_d      = S_IDLE;
          end else begin
            state_d = S_ACK_RD;
          end
        end else begin
          retiring_d = 1'b0;
          state_d    = S_ACK_START;
        end
      end

      S_ACK_START: begin
        res_valid_d  = 1'b1;
        res_action_d = ACT_START;
        res_seq_d    = rd_seq;
        res_last_d   = is_last_entry;
        idx_d        = idx_q + CNT_W'(1);
        if (is_last_entry) begin
          ring_head_d  = ring_head_q + retired_q[RING_AW-1:0];
          held_count_d = held_count_q - retired_q;
          state_d      = S_IDLE;
        end else begin
          state_d = S_ACK_RD;
        end
      end

      S_DUP_RD: begin
        state_d = S_DUP_CHK;
      end

      S_DUP_CHK: begin
        if (rd_seq == ack_q) begin
          res_valid_d  = 1'b1;
          res_action_d = ACT_TX;
          res_seq_d    = rd_seq;
          res_data_d   = rd_payload;
          res_last_d   = 1'b1;
          state_d      = S_IDLE;
        end else if (is_last_entry) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_DUP_RD;
        end
      end

      S_TMO_RD: begin
        state_d = S_TMO_TX;
      end

      S_TMO_TX: begin
        res_valid_d  = 1'b1;
        res_action_d = ACT_TX;
        res_seq_d    = rd_seq;
        res_data_d   = rd_payload;
        state_d      = S_TMO_STOP;
      end

      S_TMO_STOP: begin
        res_valid_d  = 1'b1;
        res_action_d = ACT_STOP;
        res_seq_d    = rd_seq;
        state_d      = S_TMO_START;
      end

      S_TMO_START: begin
        res_valid_d  = 1'b1;
        res_action_d = ACT_START;
        res_seq_d    = rd_seq;
        res_last_d   = 1'b1;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ring_head_q    <= '0;
      held_count_q   <= '0;
      window_base_q  <= '0;
      next_seq_q     <= '0;
      last_dup_ack_q <= '0;
      dup_count_q    <= '0;
      idx_q          <= '0;
      retired_q      <= '0;
      retiring_q     <= 1'b0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      ring_head_q    <= ring_head_d;
      held_count_q   <= held_count_d;
      window_base_q  <= window_base_d;
      next_seq_q     <= next_seq_d;
      last_dup_ack_q <= last_dup_ack_d;
      dup_count_q    <= dup_count_d;
      idx_q          <= idx_d;
      retired_q      <= retired_d;
      retiring_q     <= retiring_d;
      res_valid_q    <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ack_q        <= ack_d;
    res_action_q <= res_action_d;
    res_seq_q    <= res_seq_d;
    res_data_q   <= res_data_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o = res_valid_q;
  assign action_o       = res_action_q;
  assign seq_number_o   = res_seq_q;
  assign packet_data_o  = res_data_q;
  assign last_o         = res_last_q;

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_count_q <= CNT_W'(WINDOW_MAX))
    else $error("ring holds more packets than it has entries");

  a_open_item_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_last_q) |-> busy)
    else $error("new item could be taken before the current one finished");

  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_SEND && window_full) |=>
      (res_valid_q && res_action_q == ACT_REFUSE && res_last_q && !busy))
    else $error("full window send not refused in one result");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACK_EV || state_q == S_DUP_CHK) |-> (idx_q < held_count_q))
    else $error("ring walk beyond held packets");

endmodule
